[rtl/kabf_pkg.sv]
// Package for the Kalman angle/bias filter: data widths, register indexes,
// saturating fixed-point helpers. No dependencies.
package kabf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_WIDTH  = 31;
    localparam int DT_WIDTH   = 16;
    localparam int MAG_WIDTH  = DATA_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * MAG_WIDTH;
    localparam int QUO_WIDTH  = MAG_WIDTH + FRAC_BITS;
    localparam int DIV_STEPS  = QUO_WIDTH;
    localparam int STEP_WIDTH = $clog2(DIV_STEPS + 1);

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [MAG_WIDTH-1:0]         mag_t;

    localparam logic [1:0] REG_Q_ANGLE = 2'd0;
    localparam logic [1:0] REG_Q_BIAS  = 2'd1;
    localparam logic [1:0] REG_R_MEAS  = 2'd2;
    localparam int         IDX_WIDTH   = 2;

    localparam data_t VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // saturating add/sub
    function automatic data_t sat_add(input data_t a, input data_t b, input logic sub);
        logic signed [DATA_WIDTH:0] s;
        begin
            s = sub ? ($signed({a[DATA_WIDTH-1], a}) - $signed({b[DATA_WIDTH-1], b}))
                    : ($signed({a[DATA_WIDTH-1], a}) + $signed({b[DATA_WIDTH-1], b}));
            if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
                sat_add = s[DATA_WIDTH] ? VMIN : VMAX;
            else
                sat_add = s[DATA_WIDTH-1:0];
        end
    endfunction

    function automatic mag_t mag_of(input data_t v);
        mag_t e;
        begin
            e = {v[DATA_WIDTH-1], v};
            mag_of = v[DATA_WIDTH-1] ? (~e + 1'b1) : e;
        end
    endfunction

    // apply sign to magnitude with saturation; ovf forces limit
    function automatic data_t sign_sat(input mag_t m, input logic neg, input logic ovf);
        mag_t lim;
        mag_t mm;
        begin
            lim = neg ? mag_t'(VMAX) + 1'b1 : mag_t'(VMAX);
            mm  = (ovf || m > lim) ? lim : m;
            sign_sat = neg ? data_t'(~mm + 1'b1) : data_t'(mm);
        end
    endfunction

endpackage

[rtl/kabf_divider.sv]
// Restoring divider, one quotient bit per cycle: |n|*2^F / |d|, signed, saturated, zero for d = 0.
// Depends on kabf_pkg.
module kabf_divider (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  kabf_pkg::data_t num,
    input  kabf_pkg::data_t den,
    output logic            done,
    output kabf_pkg::data_t quo
);
    import kabf_pkg::*;

    logic                       busy_reg, busy_next;
    logic [STEP_WIDTH-1:0]      cnt_reg, cnt_next;
    logic [QUO_WIDTH-1:0]       dvd_reg, dvd_next;
    logic [MAG_WIDTH:0]         rem_reg, rem_next;
    mag_t                       dsr_reg, dsr_next;
    logic                       neg_reg, neg_next;
    logic                       zero_reg, zero_next;
    logic                       done_reg, done_next;
    logic [MAG_WIDTH:0]         trial;
    logic                       ovf;

    assign trial = {rem_reg[MAG_WIDTH-1:0], dvd_reg[QUO_WIDTH-1]};
    // quotient exceeding MAG_WIDTH bits or the signed range saturates
    assign ovf   = |dvd_reg[QUO_WIDTH-1:MAG_WIDTH];

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = {mag_of(num), {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            dsr_next  = mag_of(den);
            neg_next  = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
            zero_next = (den == '0);
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = trial - {1'b0, dsr_reg};
                dvd_next = {dvd_reg[QUO_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = trial;
                dvd_next = {dvd_reg[QUO_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_WIDTH'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign quo  = zero_reg ? '0 : sign_sat(dvd_reg[MAG_WIDTH-1:0], neg_reg, ovf);
endmodule

[rtl/kalman_angle_bias_filter_unit.sv]
// Kalman angle/bias filter, one shared multiplier and one shared add/sub ALU.
// Sequence: 30 micro-ops (11 multiplies, each a product step and a write-back step,
// 17 add/sub, two divisions each made of a start, 49 quotient steps and a write back),
// then the output state. Only one beat is worked on at a time: s_ready is low while
// busy.
// The result register frees the datapath; a new beat can start while the result waits.
// Reset (aresetn, synchronous, low): state and covariance cleared, noise
// registers back to 66 / 197 / 1966.
module kalman_angle_bias_filter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [kabf_pkg::IDX_WIDTH-1:0]      cfg_index,
    input  logic [kabf_pkg::CFG_WIDTH-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [31:0]                  s_measured_angle,
    input  logic signed [31:0]                  s_measured_rate,
    input  logic [kabf_pkg::DT_WIDTH-1:0]       s_time_step,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_filtered_angle,
    output logic signed [31:0]                  m_bias_estimate
);
    import kabf_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // micro-op kinds
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // scratch register file slots
    localparam logic [3:0] R_MA   = 4'd0;
    localparam logic [3:0] R_MR   = 4'd1;
    localparam logic [3:0] R_DT   = 4'd2;
    localparam logic [3:0] R_ANG  = 4'd3;
    localparam logic [3:0] R_BIAS = 4'd4;
    localparam logic [3:0] R_P00  = 4'd5;
    localparam logic [3:0] R_P01  = 4'd6;
    localparam logic [3:0] R_P10  = 4'd7;
    localparam logic [3:0] R_P11  = 4'd8;
    localparam logic [3:0] R_QA   = 4'd9;
    localparam logic [3:0] R_QB   = 4'd10;
    localparam logic [3:0] R_RM   = 4'd11;
    localparam logic [3:0] R_T0   = 4'd12;
    localparam logic [3:0] R_T1   = 4'd13;
    localparam logic [3:0] R_K0   = 4'd14;
    localparam logic [3:0] R_K1   = 4'd15;

    localparam int         NUM_OPS = 30;
    localparam logic [5:0] LAST_OP = 6'(NUM_OPS - 1);

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] d;
    } uop_t;

    // Program. Covariance slots hold the prior until overwritten; k0,k1 kept
    // apart, temporaries T0/T1 and the measured-rate slot reused.
    function automatic uop_t prog(input logic [5:0] pc);
        begin
            case (pc)
                // predict
                6'd0:  prog = '{OP_SUB, R_MR,  R_BIAS, R_MR};  // rate
                6'd1:  prog = '{OP_MUL, R_MR,  R_DT,   R_MR};
                6'd2:  prog = '{OP_ADD, R_ANG, R_MR,   R_ANG}; // ap
                6'd3:  prog = '{OP_ADD, R_P10, R_P01,  R_T0};
                6'd4:  prog = '{OP_MUL, R_DT,  R_T0,   R_T0};
                6'd5:  prog = '{OP_SUB, R_P00, R_T0,   R_P00};
                6'd6:  prog = '{OP_MUL, R_DT,  R_DT,   R_T0};
                6'd7:  prog = '{OP_MUL, R_T0,  R_P11,  R_T0};
                6'd8:  prog = '{OP_ADD, R_P00, R_T0,   R_P00};
                6'd9:  prog = '{OP_ADD, R_P00, R_QA,   R_P00};
                6'd10: prog = '{OP_MUL, R_DT,  R_P11,  R_T0};
                6'd11: prog = '{OP_SUB, R_P01, R_T0,   R_P01};
                6'd12: prog = '{OP_SUB, R_P10, R_T0,   R_P10};
                6'd13: prog = '{OP_ADD, R_P11, R_QB,   R_P11};
                // correct
                6'd14: prog = '{OP_SUB, R_MA,  R_ANG,  R_MA};  // y
                6'd15: prog = '{OP_ADD, R_P00, R_RM,   R_T1};  // s
                6'd16: prog = '{OP_DIV, R_P00, R_T1,   R_K0};
                6'd17: prog = '{OP_DIV, R_P10, R_T1,   R_K1};
                6'd18: prog = '{OP_MUL, R_K0,  R_MA,   R_T0};
                6'd19: prog = '{OP_ADD, R_ANG, R_T0,   R_ANG};
                6'd20: prog = '{OP_MUL, R_K1,  R_MA,   R_T0};
                6'd21: prog = '{OP_ADD, R_BIAS, R_T0,  R_BIAS};
                6'd22: prog = '{OP_MUL, R_K1,  R_P00,  R_T0};
                6'd23: prog = '{OP_SUB, R_P10, R_T0,   R_P10};
                6'd24: prog = '{OP_MUL, R_K1,  R_P01,  R_T0};
                6'd25: prog = '{OP_SUB, R_P11, R_T0,   R_P11};
                6'd26: prog = '{OP_MUL, R_K0,  R_P01,  R_T0};
                6'd27: prog = '{OP_SUB, R_P01, R_T0,   R_P01};
                6'd28: prog = '{OP_MUL, R_K0,  R_P00,  R_T0};
                6'd29: prog = '{OP_SUB, R_P00, R_T0,   R_P00};
                default: prog = '{OP_ADD, R_T0, R_T0,  R_T0};  // filler
            endcase
        end
    endfunction

    logic [1:0]  state_reg, state_next;
    logic [5:0]  pc_reg, pc_next;
    logic        phase_reg, phase_next;   // multiply: 0 = product, 1 = write back
    data_t       rf_reg [16];
    data_t       qa_reg, qb_reg, rm_reg;
    data_t       out_ang_reg, out_bias_reg;
    logic        m_valid_reg;
    logic [PROD_WIDTH-1:0] prod_reg;
    logic        prod_neg_reg;

    uop_t        uop;
    data_t       opa, opb, alu_res, mul_res;
    logic        div_start, div_done;
    data_t       div_q;
    logic        wr_en;
    data_t       wr_data;
    logic        load_in;
    logic        mul_ovf;

    assign uop = prog(pc_reg);
    assign opa = rf_reg[uop.a];
    assign opb = rf_reg[uop.b];
    assign alu_res = sat_add(opa, opb, uop.op == OP_SUB);

    // product of magnitudes, shifted down by FRAC_BITS at write back
    assign mul_ovf = |prod_reg[PROD_WIDTH-1:MAG_WIDTH+FRAC_BITS];
    assign mul_res = sign_sat(prod_reg[MAG_WIDTH+FRAC_BITS-1:FRAC_BITS], prod_neg_reg, mul_ovf);

    kabf_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (opa),
        .den     (opb),
        .done    (div_done),
        .quo     (div_q)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign load_in = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        div_start  = 1'b0;
        wr_en      = 1'b0;
        wr_data    = alu_res;
        case (state_reg)
            ST_IDLE: begin
                if (load_in) begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                    phase_next = 1'b0;
                end
            end
            ST_RUN: begin
                if (uop.op == OP_DIV) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else if (uop.op == OP_MUL && !phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    wr_data    = (uop.op == OP_MUL) ? mul_res : alu_res;
                    phase_next = 1'b0;
                    if (pc_reg == LAST_OP) begin
                        state_next = ST_OUT;
                    end else begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    wr_en      = 1'b1;
                    wr_data    = div_q;
                    state_next = ST_RUN;
                    pc_next    = pc_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            qa_reg      <= data_t'(66);
            qb_reg      <= data_t'(197);
            rm_reg      <= data_t'(1966);
            for (int i = 0; i < 16; i++) rf_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            phase_reg <= phase_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_Q_ANGLE: qa_reg <= data_t'({1'b0, cfg_data});
                    REG_Q_BIAS:  qb_reg <= data_t'({1'b0, cfg_data});
                    REG_R_MEAS:  rm_reg <= data_t'({1'b0, cfg_data});
                    default: ;
                endcase
            end
            if (load_in) begin
                rf_reg[R_MA] <= s_measured_angle;
                rf_reg[R_MR] <= s_measured_rate;
                rf_reg[R_DT] <= data_t'({1'b0, s_time_step});
                rf_reg[R_QA] <= qa_reg;
                rf_reg[R_QB] <= qb_reg;
                rf_reg[R_RM] <= rm_reg;
            end else if (wr_en) begin
                rf_reg[uop.d] <= wr_data;
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready))
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
        prod_reg     <= mag_of(opa) * mag_of(opb);
        prod_neg_reg <= opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            out_ang_reg  <= rf_reg[R_ANG];
            out_bias_reg <= rf_reg[R_BIAS];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_angle = out_ang_reg;
    assign m_bias_estimate  = out_bias_reg;

    // a taken beat moves the sequencer to the run state
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_in |=> state_reg == ST_RUN)
        else $error("sequencer did not start");
    // divider only started from the run state
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> state_reg == ST_RUN && uop.op == OP_DIV)
        else $error("stray divider start");
    // divider completes only while waited for
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done out of sequence");
endmodule
